// File: src/wmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmac_pkg
// Shared types and codes for the weighing median/average/cluster block.
// ----------------------------------------------------------------------------
package wmac_pkg;

  localparam int unsigned GRAM_W = 16;
  localparam int unsigned BAND_W = 12;
  localparam int unsigned STAT_W = 2;
  localparam logic [BAND_W-1:0] BAND_RESET = 12'd100;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_SINGLE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,     // wait for a sample
    S_MED,      // one compare per cycle to rank the new window
    S_AVG,      // update moving sum, write store
    S_OUTER,    // start candidate i
    S_INNER,    // count members for candidate i
    S_SUM_RD,   // start total pass
    S_SUM,      // accumulate members of best cluster
    S_DIV,      // restoring division, one bit a cycle
    S_OUT       // hold result beat
  } state_t;

  // Divider control bundle.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: src/wmac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmac_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmac_div
  import wmac_pkg::*;
#(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_sts_t         sts,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (ctl.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) den_r <= den;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

// File: src/weight_median_average_cluster_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_median_average_cluster_unit
// Scale sample filter: running median, moving sum, densest-band mean.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel carries one sample a beat; in_last_sample closes a batch.
//   out_ channel carries one weight/status beat per closed batch.
//   cfg_we writes band_halfwidth; write only while the block is idle.
// Timing:
//   A sample is ranked against the window (MEDIAN_TAPS once full) before the
//   next sample is accepted: the median is ranked by one shared comparator,
//   one pair a cycle. A last sample then runs the cluster search over the N
//   stored sums (one compare a cycle), a restoring divide if the best band
//   holds more than one sum, and the result beat.
//   in_stall is high whenever the block is busy.
// Reset: synchronous active low; clears batch state, band reverts to 100.
//   The sum store is not cleared; only entries of the current batch are read.
// Output stall: the result beat holds until out_stall is low; no new
//   sample is taken meanwhile.
// ----------------------------------------------------------------------------
module weight_median_average_cluster_unit
  import wmac_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned MEDIAN_TAPS = 5,
  parameter int unsigned AVG_TAPS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BAND_W-1:0] cfg_band_halfwidth,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [GRAM_W-1:0] in_sample_grams,
  input  logic              in_last_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [GRAM_W-1:0] out_weight_grams,
  output logic [STAT_W-1:0] out_status
);

  localparam int unsigned MT_W  = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int unsigned MF_W  = $clog2(MEDIAN_TAPS + 1);
  localparam int unsigned AT_W  = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int unsigned SUM_W = GRAM_W + $clog2(AVG_TAPS + 1);
  localparam int unsigned ADR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TOL_W = BAND_W + $clog2(AVG_TAPS + 1);
  localparam int unsigned TOT_W = SUM_W + CNT_W;
  localparam int unsigned DEN_W = CNT_W + $clog2(AVG_TAPS + 1) + 1;
  localparam int unsigned NUM_W = TOT_W + 1;

  state_t state_r, state_nxt;

  logic [BAND_W-1:0] band_r;
  logic [GRAM_W-1:0] win_r [MEDIAN_TAPS];
  logic [MF_W-1:0]   fill_r;
  logic [GRAM_W-1:0] dly_r [AVG_TAPS];
  logic [SUM_W-1:0]  rsum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AT_W-1:0]   slot_r;
  logic              ovf_r, last_r;

  // median ranking
  logic [MT_W-1:0]   mi_r, mj_r;
  logic [MF_W-1:0]   rank_r;
  logic [GRAM_W-1:0] med_r;

  // store
  logic [SUM_W-1:0]  mem [MAX_SAMPLES];
  logic [SUM_W-1:0]  rd_r;
  logic [ADR_W-1:0]  rd_adr;
  logic              mem_we;
  logic [ADR_W-1:0]  wr_adr;
  logic [SUM_W-1:0]  wr_dat;

  // cluster search
  logic [CNT_W-1:0]  nsums_r, ci_r, cj_r, n_r, best_n_r, rdj_r;
  logic [ADR_W-1:0]  best_i_r;
  logic [SUM_W-1:0]  c_r;
  logic [TOT_W-1:0]  tot_r;
  logic              rd_ok_r, cval_r;
  logic [GRAM_W-1:0] wout;
  logic [STAT_W-1:0] sout;

  div_ctl_t          dctl;
  div_sts_t          dsts;
  logic [NUM_W-1:0]  dquo;
  logic [DEN_W-1:0]  dden;
  logic [NUM_W-1:0]  dnum;

  logic              acc;
  logic [TOL_W-1:0]  tol;
  logic [SUM_W-1:0]  diff;
  logic              in_band;
  logic [GRAM_W-1:0] wi, wj;
  logic              lt_cnt;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign tol      = TOL_W'(band_r) * TOL_W'(AVG_TAPS);
  assign diff     = (rd_r >= c_r) ? rd_r - c_r : c_r - rd_r;
  assign in_band  = ({{(TOL_W > SUM_W ? TOL_W - SUM_W : 0){1'b0}}, diff} <=
                     {{(SUM_W > TOL_W ? SUM_W - TOL_W : 0){1'b0}}, tol});

  // shared comparator: element j ranks below element i (ties by position)
  assign wi     = win_r[mi_r];
  assign wj     = win_r[mj_r];
  assign lt_cnt = (wj < wi) || ((wj == wi) && (mj_r < mi_r));

  assign dden = DEN_W'({best_n_r, 1'b0}) * DEN_W'(AVG_TAPS);
  assign dnum = {tot_r, 1'b0} + NUM_W'(dden >> 1);
  assign dctl.start = (state_r == S_SUM) && !rd_ok_r && (cj_r == nsums_r) &&
                      (rdj_r == nsums_r) && (best_n_r > CNT_W'(1));

  wmac_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dden),
    .sts(dsts), .quo(dquo)
  );

  assign rd_adr = rdj_r[ADR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_adr] <= wr_dat;
    rd_r <= mem[rd_adr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = (cnt_r < CNT_W'(MAX_SAMPLES)) ? S_MED :
                                    (in_last_sample ? S_OUTER : S_IDLE);
      S_MED:   if (mi_r == MT_W'(fill_r - 1'b1) && mj_r == MT_W'(fill_r - 1'b1))
                 state_nxt = S_AVG;
      S_AVG:   state_nxt = last_r ? S_OUTER : S_IDLE;
      S_OUTER: state_nxt = (ci_r == nsums_r) ? S_SUM_RD : S_INNER;
      S_INNER: if (!rd_ok_r && cj_r == nsums_r && rdj_r == nsums_r)
                 state_nxt = S_OUTER;
      S_SUM_RD: state_nxt = S_SUM;
      S_SUM:   if (!rd_ok_r && cj_r == nsums_r && rdj_r == nsums_r)
                 state_nxt = (best_n_r > CNT_W'(1)) ? S_DIV : S_OUT;
      S_DIV:   if (dsts.done) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    mem_we = 1'b0;
    wr_adr = cnt_r[ADR_W-1:0] - ADR_W'(AVG_TAPS - 1);
    wr_dat = rsum_r + SUM_W'(med_r) - SUM_W'(dly_r[slot_r]);
    if (state_r == S_AVG && cnt_r >= CNT_W'(AVG_TAPS - 1)) mem_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r   <= BAND_RESET;
      fill_r   <= '0;
      rsum_r   <= '0;
      cnt_r    <= '0;
      slot_r   <= '0;
      ovf_r    <= 1'b0;
      last_r   <= 1'b0;
      rd_ok_r  <= 1'b0;
      for (int k = 0; k < AVG_TAPS; k++) dly_r[k] <= '0;
    end else begin
      if (cfg_we) band_r <= cfg_band_halfwidth;
      rd_ok_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          last_r <= in_last_sample;
          if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
            // shift in the new sample
            if (fill_r == MF_W'(MEDIAN_TAPS)) begin
              for (int k = 0; k < MEDIAN_TAPS - 1; k++) win_r[k] <= win_r[k+1];
              win_r[MEDIAN_TAPS-1] <= in_sample_grams;
            end else begin
              win_r[fill_r[MT_W-1:0]] <= in_sample_grams;
              fill_r <= fill_r + 1'b1;
            end
            mi_r   <= '0;
            mj_r   <= '0;
            rank_r <= '0;
          end else begin
            ovf_r <= 1'b1;
          end
          nsums_r  <= (cnt_r >= CNT_W'(AVG_TAPS)) ? cnt_r - CNT_W'(AVG_TAPS - 1) : '0;
          ci_r     <= '0;
          best_n_r <= '0;
          best_i_r <= '0;
        end
        S_MED: begin
          // rank element i; the one with rank fill/2 is the upper median
          if (mj_r == MT_W'(fill_r - 1'b1)) begin
            if (MF_W'(rank_r + MF_W'(lt_cnt)) == (fill_r >> 1)) med_r <= wi;
            mi_r   <= mi_r + 1'b1;
            mj_r   <= '0;
            rank_r <= '0;
          end else begin
            rank_r <= rank_r + MF_W'(lt_cnt);
            mj_r   <= mj_r + 1'b1;
          end
        end
        S_AVG: begin
          rsum_r <= wr_dat;
          dly_r[slot_r] <= med_r;
          slot_r <= (slot_r == AT_W'(AVG_TAPS - 1)) ? '0 : slot_r + 1'b1;
          cnt_r  <= cnt_r + 1'b1;
          nsums_r <= (cnt_r + 1'b1 >= CNT_W'(AVG_TAPS)) ?
                     cnt_r - CNT_W'(AVG_TAPS - 2) : '0;
          ci_r <= '0;
          best_n_r <= '0;
          best_i_r <= '0;
        end
        S_OUTER: begin
          rdj_r  <= ci_r;
          cval_r <= 1'b1;
          cj_r   <= '0;
          n_r    <= '0;
        end
        S_INNER, S_SUM: begin
          // first read after rdj set loads c, then stream all j
          if (cval_r) begin
            cval_r <= 1'b0;
            if (state_r == S_INNER) c_r <= mem[rdj_r[ADR_W-1:0]];
            else c_r <= mem[best_i_r];
            rdj_r  <= '0;
          end else begin
            if (rdj_r != nsums_r) begin
              rdj_r   <= rdj_r + 1'b1;
              rd_ok_r <= 1'b1;
            end
            if (rd_ok_r) begin
              cj_r <= cj_r + 1'b1;
              if (in_band) begin
                n_r   <= n_r + 1'b1;
                tot_r <= tot_r + TOT_W'(rd_r);
              end
            end else if (cj_r == nsums_r && rdj_r == nsums_r &&
                         state_r == S_INNER) begin
              if (n_r > best_n_r) begin
                best_n_r <= n_r;
                best_i_r <= ci_r[ADR_W-1:0];
              end
              ci_r <= ci_r + 1'b1;
            end
          end
        end
        S_SUM_RD: begin
          cval_r <= 1'b1;
          cj_r   <= '0;
          tot_r  <= '0;
          rdj_r  <= '0;
        end
        S_DIV: ;
        S_OUT: if (!out_stall) begin
          for (int k = 0; k < AVG_TAPS; k++) dly_r[k] <= '0;
          fill_r <= '0;
          rsum_r <= '0;
          cnt_r  <= '0;
          slot_r <= '0;
          ovf_r  <= 1'b0;
          last_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nsums_r == '0) begin
      wout = '0;
      sout = ST_EMPTY;
    end else if (best_n_r <= CNT_W'(1)) begin
      wout = '0;
      sout = ST_SINGLE;
    end else begin
      wout = (dquo > NUM_W'(16'hFFFF)) ? 16'hFFFF : dquo[GRAM_W-1:0];
      sout = ovf_r ? ST_DROPPED : ST_OK;
    end
  end

  assign out_valid        = (state_r == S_OUT);
  assign out_weight_grams = wout;
  assign out_status       = sout;

endmodule

// File: verif/weight_median_average_cluster_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_median_average_cluster_unit_tb
// Drives weighing batches through the filter block and checks every weight
// and status beat against an in-bench model of median, moving sum and
// densest-band mean, across band settings and sender/receiver idling modes.
// ----------------------------------------------------------------------------
module weight_median_average_cluster_unit_tb;
  import wmac_pkg::*;

  localparam int unsigned CAP      = 256;
  localparam int unsigned MED_N    = 5;
  localparam int unsigned AVG_N    = 4;
  localparam int unsigned WDOG_MAX = 400000;
  localparam int unsigned SETTLE   = 100;

  typedef struct {
    logic [GRAM_W-1:0] grams;
    logic              last;
  } sample_t;

  typedef struct {
    logic [GRAM_W-1:0] weight;
    logic [STAT_W-1:0] status;
  } weighing_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BAND_W-1:0] cfg_band_halfwidth;
  logic              in_valid;
  logic              in_stall;
  logic [GRAM_W-1:0] in_sample_grams;
  logic              in_last_sample;
  logic              out_valid;
  logic              out_stall;
  logic [GRAM_W-1:0] out_weight_grams;
  logic [STAT_W-1:0] out_status;

  sample_t     pending_samples[$];
  weighing_t   expected_weighings[$];
  int unsigned errors = 0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned quiet_cycles = 0;

  // model state
  logic [BAND_W-1:0] band;
  logic [GRAM_W-1:0] win[MED_N];
  int unsigned       win_fill;
  logic [GRAM_W-1:0] avg_ring[AVG_N];
  longint unsigned   moving_sum;
  int unsigned       taken;
  longint unsigned   sums[CAP];
  bit                dropped;

  weight_median_average_cluster_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_band_halfwidth (cfg_band_halfwidth),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_grams    (in_sample_grams),
    .in_last_sample     (in_last_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_weight_grams   (out_weight_grams),
    .out_status         (out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic clear_batch_model();
    for (int i = 0; i < MED_N; i++) win[i] = '0;
    for (int i = 0; i < AVG_N; i++) avg_ring[i] = '0;
    win_fill   = 0;
    moving_sum = 0;
    taken      = 0;
    dropped    = 0;
  endtask

  task automatic close_batch();
    int unsigned     n_sums;
    int unsigned     best_i;
    int unsigned     best_n;
    int unsigned     members;
    longint unsigned tol;
    longint unsigned gap;
    longint unsigned total;
    longint unsigned div;
    longint unsigned mean;
    weighing_t       res;
    n_sums = (taken >= AVG_N) ? taken - AVG_N + 1 : 0;
    if (n_sums > CAP) n_sums = CAP;
    tol    = longint'(band) * AVG_N;
    best_i = 0;
    best_n = 0;
    for (int i = 0; i < n_sums; i++) begin
      members = 0;
      for (int j = 0; j < n_sums; j++) begin
        gap = (sums[j] >= sums[i]) ? sums[j] - sums[i] : sums[i] - sums[j];
        if (gap <= tol) members++;
      end
      // strict compare keeps the lowest index on ties
      if (members > best_n) begin
        best_n = members;
        best_i = i;
      end
    end
    res.weight = '0;
    if (n_sums == 0) begin
      res.status = ST_EMPTY;
    end else if (best_n <= 1) begin
      res.status = ST_SINGLE;
    end else begin
      total = 0;
      for (int j = 0; j < n_sums; j++) begin
        gap = (sums[j] >= sums[best_i]) ? sums[j] - sums[best_i]
                                        : sums[best_i] - sums[j];
        if (gap <= tol) total += sums[j];
      end
      div  = longint'(best_n) * AVG_N;
      mean = (2 * total + div) / (2 * div);
      if (mean > 64'hFFFF) mean = 64'hFFFF;
      res.weight = mean[GRAM_W-1:0];
      res.status = dropped ? ST_DROPPED : ST_OK;
    end
    expected_weighings = {expected_weighings, res};
  endtask

  task automatic filter_and_cluster(input sample_t s);
    logic [GRAM_W-1:0] sorted[MED_N];
    logic [GRAM_W-1:0] v;
    logic [GRAM_W-1:0] med;
    int                j;
    int unsigned       slot;
    if (taken < CAP) begin
      if (win_fill >= MED_N) begin
        for (int i = 1; i < MED_N; i++) win[i-1] = win[i];
        win[MED_N-1] = s.grams;
      end else begin
        win[win_fill] = s.grams;
        win_fill++;
      end
      for (int i = 0; i < win_fill; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      med  = sorted[win_fill / 2];
      slot = taken % AVG_N;
      moving_sum = moving_sum + med - avg_ring[slot];
      avg_ring[slot] = med;
      taken++;
      if (taken >= AVG_N) sums[taken - AVG_N] = moving_sum;
    end else begin
      dropped = 1;
    end
    if (s.last) begin
      close_batch();
      clear_batch_model();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_sample_grams <= '0;
      in_last_sample  <= 1'b0;
      clear_batch_model();
    end else if (!in_valid || !in_stall) begin
      if (in_valid) filter_and_cluster('{in_sample_grams, in_last_sample});
      if (pending_samples.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        in_valid        <= 1'b1;
        in_sample_grams <= pending_samples[0].grams;
        in_last_sample  <= pending_samples[0].last;
        pending_samples.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    weighing_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_weighings.size() == 0) begin
        $display("%0t: unexpected beat weight=%0d status=%0d",
                 $time, out_weight_grams, out_status);
        errors++;
      end else begin
        exp_w = expected_weighings[0];
        expected_weighings.delete(0);
        if (out_weight_grams !== exp_w.weight) begin
          $display("%0t: weight expected %0d actual %0d",
                   $time, exp_w.weight, out_weight_grams);
          errors++;
        end
        if (out_status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_w.status, out_status);
          errors++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99, 0) < snk_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("weight_median_average_cluster_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_batch(input int unsigned len, input int unsigned base,
                             input int unsigned spread, input int unsigned noise_pct);
    sample_t     s;
    int          g;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        g = $urandom_range(65535, 0);
      end else begin
        g = int'(base) + int'($urandom_range(2 * spread, 0)) - int'(spread);
        if (g < 0) g = 0;
        if (g > 65535) g = 65535;
      end
      s.grams = g[GRAM_W-1:0];
      s.last  = (i == len - 1);
      pending_samples = {pending_samples, s};
    end
  endtask

  task automatic queue_list(input int unsigned vals[$]);
    sample_t s;
    foreach (vals[i]) begin
      s.grams = vals[i][GRAM_W-1:0];
      s.last  = (i == vals.size() - 1);
      pending_samples = {pending_samples, s};
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() > 0 || in_valid || expected_weighings.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_band(input logic [BAND_W-1:0] value);
    cfg_we             <= 1'b1;
    cfg_band_halfwidth <= value;
    band = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase_band[8] = '{100, 0, 4095, 7, 1, 300, 4094, 25};
    int unsigned modes[4][2]   = '{'{0, 0}, '{85, 0}, '{0, 85}, '{35, 35}};
    int unsigned quota;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_band_halfwidth = '0;
    band               = BAND_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: too few samples, cluster of one, extremes, tie, plain cluster
    queue_list('{65535});
    queue_list('{0, 65535, 0});
    queue_list('{65535, 65535, 65535, 65535});
    queue_list('{0, 0, 0, 0, 0});
    queue_list('{65535, 65535, 65535, 65535, 65535, 65535});
    queue_list('{1000, 1000, 1000, 1000, 5000, 5000, 5000});
    drain();

    for (int p = 0; p < 8; p++) begin
      write_band(BAND_W'(p == 3 ? $urandom_range(4095, 0) : phase_band[p]));
      src_idle_pct  = modes[p % 4][0];
      snk_stall_pct = modes[p % 4][1];
      quota = pending_samples.size() + 110;
      // capacity overflow batch; last one ends on a dropped sample
      if (p == 1) queue_batch(262, $urandom_range(65535, 0), 40, 5);
      if (p == 6) queue_batch(300, $urandom_range(65535, 0), 200, 10);
      while (pending_samples.size() < quota)
        queue_batch($urandom_range(24, 1), $urandom_range(65535, 0),
                    $urandom_range(3, 0) == 0 ? 3000 : $urandom_range(150, 0),
                    $urandom_range(20, 0));
      // each phase end holds the sender until every weighing has come back
      drain();
    end

    if (errors == 0) begin
      $display("weight_median_average_cluster_unit verification clean");
    end else begin
      $display("weight_median_average_cluster_unit verification failed");
    end
    $finish;
  end

endmodule
